// ===== hdl/pit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_pkg: shared constants for the barycentric point-in-triangle block
// Defaults, result width and divider depth used by the files of the block.
// ----------------------------------------------------------------------------
package pit_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// Width of one result weight.
	localparam int OUT_W = 24;

	// Quotient bits kept by the divider: the doubled quotient used for
	// rounding reaches twice the output range before it saturates.
	localparam int QUO_W = OUT_W + 2;

	// Divider depth: operand stage, range check stage, one stage per
	// quotient bit and the rounding stage.
	localparam int DIV_LAT = QUO_W + 3;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== hdl/pit_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_in_if: input channel
// Carries the triangle corners a, b, c and the tested point p.
// ----------------------------------------------------------------------------
interface pit_in_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] ax;
	logic signed [W-1:0] ay;
	logic signed [W-1:0] az;
	logic signed [W-1:0] bx;
	logic signed [W-1:0] by_coord;
	logic signed [W-1:0] bz;
	logic signed [W-1:0] cx;
	logic signed [W-1:0] cy;
	logic signed [W-1:0] cz;
	logic signed [W-1:0] px;
	logic signed [W-1:0] py;
	logic signed [W-1:0] pz;

	modport source (
		output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
		input  ready
	);
	modport sink (
		input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/pit_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_out_if: result channel
// Carries the three barycentric weights and the inside and degenerate flags.
// ----------------------------------------------------------------------------
interface pit_out_if;
	import pit_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] weight_u;
	logic signed [OUT_W-1:0] weight_v;
	logic signed [OUT_W-1:0] weight_w;
	logic                    inside_res;
	logic                    degenerate;

	modport source (
		output valid, weight_u, weight_v, weight_w, inside_res, degenerate,
		input  ready
	);
	modport sink (
		input  valid, weight_u, weight_v, weight_w, inside_res, degenerate,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/pit_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_div: pipelined fixed-point divider
// Rounds num * 2^FRAC / den to nearest, ties away from zero, and saturates
// to the result width. One restoring step per stage.
// ----------------------------------------------------------------------------
module pit_div #(
	parameter int NW   = 37,
	parameter int FRAC = 16
) (
	input  wire                             clk,
	input  wire                             en,
	input  wire  signed [NW-1:0]            num,
	input  wire  signed [NW-1:0]            den,
	output logic signed [pit_pkg::OUT_W-1:0] res
);
	import pit_pkg::*;

	localparam int TW = NW + FRAC + 1;
	localparam int CW = TW + QUO_W;

	logic          neg_s1;
	logic [NW-1:0] n_s1;
	logic [NW-1:0] d_s1;

	logic [NW-1:0]    rem_s [QUO_W+1];
	logic [QUO_W-1:0] low_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic [NW-1:0]    d_s   [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];

	logic [TW-1:0] ext;
	logic [TW-1:0] ext_hi;
	logic [QUO_W:0] q_inc;
	logic [QUO_W-1:0] q_rnd;

	// Magnitudes and result sign.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[NW-1] ^ den[NW-1];
			n_s1   <= num[NW-1] ? NW'(-num) : NW'(num);
			d_s1   <= den[NW-1] ? NW'(-den) : NW'(den);
		end
	end

	// The doubled quotient must fit in QUO_W bits, else the weight saturates.
	assign ext    = {n_s1, {(FRAC+1){1'b0}}};
	assign ext_hi = ext >> QUO_W;

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= CW'(ext) >= (CW'(d_s1) << QUO_W);
			rem_s[0] <= ext_hi[NW-1:0];
			low_s[0] <= ext[QUO_W-1:0];
			quo_s[0] <= '0;
			d_s[0]   <= d_s1;
			neg_s[0] <= neg_s1;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [NW:0] trial;
		logic        take;
		logic [NW:0] diff;

		assign trial = {rem_s[k], low_s[k][QUO_W-1]};
		assign take  = trial >= {1'b0, d_s[k]};
		assign diff  = trial - {1'b0, d_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[NW-1:0] : trial[NW-1:0];
				low_s[k+1] <= low_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], take};
				d_s[k+1]   <= d_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// The quotient carries one extra bit, so adding one and halving rounds.
	assign q_inc = {1'b0, quo_s[QUO_W]} + (QUO_W+1)'(1);
	assign q_rnd = q_inc[QUO_W:1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QUO_W]) begin
				if (ovf_s[QUO_W] || q_rnd > QUO_W'(OUT_MAX) + QUO_W'(1)) begin
					res <= OUT_MIN;
				end else begin
					res <= OUT_W'(-q_rnd);
				end
			end else begin
				if (ovf_s[QUO_W] || q_rnd > QUO_W'(OUT_MAX)) begin
					res <= OUT_MAX;
				end else begin
					res <= OUT_W'(q_rnd);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/barycentric_point_in_triangle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_point_in_triangle: barycentric weights of a point in 3D
// Takes one word per cycle while the result side is ready and returns one
// result word per input word. The pipeline holds seven stages of differences,
// cross product, plane choice and 2D areas, three parallel dividers that
// retire one quotient bit per stage, and the output register. Back-pressure
// stalls the whole pipeline; throughput is one word per cycle while the
// result side is ready. Weights are signed with FRAC_BITS fraction bits,
// rounded to nearest and saturated; a triangle whose chosen normal
// component is zero gives zero weights and the degenerate flag.
// ----------------------------------------------------------------------------
module barycentric_point_in_triangle #(
	parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = pit_pkg::FRAC_BITS_DEF
) (
	input  wire clk,
	input  wire arst_n,
	pit_in_if.sink    pts,
	pit_out_if.source res
);
	import pit_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int EW = W + 1;
	localparam int PW = 2 * EW;
	localparam int MW = PW + 1;
	localparam int DW = MW + 1;
	localparam int NW = DW + 1;
	localparam int NS = 7 + DIV_LAT;

	logic en;
	logic vld_s [NS];

	logic signed [W-1:0] av [3];
	logic signed [W-1:0] bv [3];
	logic signed [W-1:0] cv [3];
	logic signed [W-1:0] pv [3];

	assign av[0] = pts.ax;
	assign av[1] = pts.ay;
	assign av[2] = pts.az;
	assign bv[0] = pts.bx;
	assign bv[1] = pts.by_coord;
	assign bv[2] = pts.bz;
	assign cv[0] = pts.cx;
	assign cv[1] = pts.cy;
	assign cv[2] = pts.cz;
	assign pv[0] = pts.px;
	assign pv[1] = pts.py;
	assign pv[2] = pts.pz;

	assign en        = !res.valid || res.ready;
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pts.valid;
			for (int k = 1; k < NS; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Stage 1: edge and point differences per axis.
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [EW-1:0] pb_s1 [3];
	logic signed [EW-1:0] bc_s1 [3];
	logic signed [EW-1:0] pc_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e1_s1[k] <= EW'(bv[k]) - EW'(av[k]);
				e2_s1[k] <= EW'(cv[k]) - EW'(av[k]);
				pb_s1[k] <= EW'(pv[k]) - EW'(bv[k]);
				bc_s1[k] <= EW'(bv[k]) - EW'(cv[k]);
				pc_s1[k] <= EW'(pv[k]) - EW'(cv[k]);
			end
		end
	end

	// Stage 2: partial products of the normal.
	logic signed [PW-1:0] cp_s2 [6];
	logic signed [EW-1:0] e2_s2 [3];
	logic signed [EW-1:0] pb_s2 [3];
	logic signed [EW-1:0] bc_s2 [3];
	logic signed [EW-1:0] pc_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s2[0] <= PW'(e1_s1[1]) * PW'(e2_s1[2]);
			cp_s2[1] <= PW'(e1_s1[2]) * PW'(e2_s1[1]);
			cp_s2[2] <= PW'(e1_s1[2]) * PW'(e2_s1[0]);
			cp_s2[3] <= PW'(e1_s1[0]) * PW'(e2_s1[2]);
			cp_s2[4] <= PW'(e1_s1[0]) * PW'(e2_s1[1]);
			cp_s2[5] <= PW'(e1_s1[1]) * PW'(e2_s1[0]);
			e2_s2 <= e2_s1;
			pb_s2 <= pb_s1;
			bc_s2 <= bc_s1;
			pc_s2 <= pc_s1;
		end
	end

	// Stage 3: normal components.
	logic signed [MW-1:0] m_s3  [3];
	logic signed [EW-1:0] e2_s3 [3];
	logic signed [EW-1:0] pb_s3 [3];
	logic signed [EW-1:0] bc_s3 [3];
	logic signed [EW-1:0] pc_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				m_s3[k] <= MW'(cp_s2[2*k]) - MW'(cp_s2[2*k+1]);
			end
			e2_s3 <= e2_s2;
			pb_s3 <= pb_s2;
			bc_s3 <= bc_s2;
			pc_s3 <= pc_s2;
		end
	end

	// Stage 4: drop the axis of the largest normal component and pick the
	// operands of the two areas in the remaining plane.
	logic [MW-1:0] am [3];
	logic [1:0]    i1;
	logic [1:0]    i2;
	logic signed [DW-1:0] dsel;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			am[k] = m_s3[k][MW-1] ? MW'(-m_s3[k]) : MW'(m_s3[k]);
		end
		if (am[0] >= am[1] && am[0] >= am[2]) begin
			i1   = 2'd1;
			i2   = 2'd2;
			dsel = DW'(m_s3[0]);
		end else if (am[1] >= am[2]) begin
			i1   = 2'd0;
			i2   = 2'd2;
			dsel = -DW'(m_s3[1]);
		end else begin
			i1   = 2'd0;
			i2   = 2'd1;
			dsel = DW'(m_s3[2]);
		end
	end

	logic signed [EW-1:0] op_s4 [8];
	logic signed [DW-1:0] d_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4[0] <= pb_s3[i1];
			op_s4[1] <= bc_s3[i2];
			op_s4[2] <= bc_s3[i1];
			op_s4[3] <= pb_s3[i2];
			op_s4[4] <= pc_s3[i1];
			op_s4[5] <= e2_s3[i2];
			op_s4[6] <= e2_s3[i1];
			op_s4[7] <= pc_s3[i2];
			d_s4     <= dsel;
		end
	end

	// Stage 5: area products.
	logic signed [PW-1:0] ap_s5 [4];
	logic signed [DW-1:0] d_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				ap_s5[k] <= PW'(op_s4[2*k]) * PW'(op_s4[2*k+1]);
			end
			d_s5 <= d_s4;
		end
	end

	// Stage 6: signed areas.
	logic signed [MW-1:0] nu_s6;
	logic signed [MW-1:0] nv_s6;
	logic signed [DW-1:0] d_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			nu_s6 <= MW'(ap_s5[0]) - MW'(ap_s5[1]);
			nv_s6 <= MW'(ap_s5[2]) - MW'(ap_s5[3]);
			d_s6  <= d_s5;
		end
	end

	// Stage 7: third area and divider operands.
	logic signed [NW-1:0] nu_s7;
	logic signed [NW-1:0] nv_s7;
	logic signed [NW-1:0] nw_s7;
	logic signed [NW-1:0] d_s7;
	logic                 deg_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			nu_s7  <= NW'(nu_s6);
			nv_s7  <= NW'(nv_s6);
			nw_s7  <= NW'(d_s6) - NW'(nu_s6) - NW'(nv_s6);
			d_s7   <= NW'(d_s6);
			deg_s7 <= d_s6 == '0;
		end
	end

	logic signed [OUT_W-1:0] qu;
	logic signed [OUT_W-1:0] qv;
	logic signed [OUT_W-1:0] qw;

	pit_div #(.NW(NW), .FRAC(FRAC_BITS)) u_div_u (
		.clk(clk), .en(en), .num(nu_s7), .den(d_s7), .res(qu)
	);
	pit_div #(.NW(NW), .FRAC(FRAC_BITS)) u_div_v (
		.clk(clk), .en(en), .num(nv_s7), .den(d_s7), .res(qv)
	);
	pit_div #(.NW(NW), .FRAC(FRAC_BITS)) u_div_w (
		.clk(clk), .en(en), .num(nw_s7), .den(d_s7), .res(qw)
	);

	// The degenerate flag rides alongside the dividers.
	logic deg_dly_q [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			deg_dly_q[0] <= deg_s7;
			for (int k = 1; k < DIV_LAT; k++) deg_dly_q[k] <= deg_dly_q[k-1];
		end
	end

	logic deg_f;
	assign deg_f = deg_dly_q[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (en) begin
			res.valid <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.weight_u   <= deg_f ? '0 : qu;
			res.weight_v   <= deg_f ? '0 : qv;
			res.weight_w   <= deg_f ? '0 : qw;
			res.inside_res <= !deg_f && !qu[OUT_W-1] && !qv[OUT_W-1] && !qw[OUT_W-1];
			res.degenerate <= deg_f;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pit_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_check: port checker for the barycentric point-in-triangle block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module pit_check (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             out_valid,
	input wire                             out_ready,
	input wire signed [pit_pkg::OUT_W-1:0] weight_u,
	input wire signed [pit_pkg::OUT_W-1:0] weight_v,
	input wire signed [pit_pkg::OUT_W-1:0] weight_w,
	input wire                             inside_res,
	input wire                             degenerate
);
	import pit_pkg::*;

	// A degenerate triangle gives zero weights and is never inside.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |->
			weight_u == '0 && weight_v == '0 && weight_w == '0 && !inside_res)
		else $error("degenerate word carries nonzero weights");

	// The inside flag agrees with the signs of the weights.
	a_inside_signs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |->
			inside_res == (!weight_u[OUT_W-1] && !weight_v[OUT_W-1]
				&& !weight_w[OUT_W-1]))
		else $error("inside flag disagrees with weight signs");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(weight_u) && $stable(weight_v) && $stable(weight_w)
			&& $stable(inside_res) && $stable(degenerate))
		else $error("result word changed while stalled");

endmodule

bind barycentric_point_in_triangle pit_check u_pit_check (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.weight_u(res.weight_u),
	.weight_v(res.weight_v),
	.weight_w(res.weight_w),
	.inside_res(res.inside_res),
	.degenerate(res.degenerate)
);

`default_nettype wire
